[rtl/core/ccdv_pkg.sv]
package ccdv_pkg;

   localparam int CHAR_WIDTH   = 8;
   localparam int POS_WIDTH    = 4;
   localparam int SUM_WIDTH    = 10;
   localparam int DIGIT_WIDTH  = 4;
   localparam int TYPE_WIDTH   = 2;
   localparam int STATUS_WIDTH = 3;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;

   localparam logic [POS_WIDTH-1:0] POS_MAX       = 4'd15;
   localparam logic [POS_WIDTH-1:0] POS_LAST_CPF  = 4'd10;
   localparam logic [POS_WIDTH-1:0] POS_LAST_CNPJ = 4'd13;

   localparam logic [TYPE_WIDTH-1:0] TYPE_UNKNOWN = 2'd0;
   localparam logic [TYPE_WIDTH-1:0] TYPE_CPF     = 2'd1;
   localparam logic [TYPE_WIDTH-1:0] TYPE_CNPJ    = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_LENGTH   = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_NON_DIGIT    = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_FIRST_WRONG  = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_SECOND_WRONG = 3'd4;

   // floor(2048/11); the quotient estimate is low by at most one.
   localparam int RECIP_11 = 186;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] person_first;
      logic [SUM_WIDTH-1:0] person_second;
      logic [SUM_WIDTH-1:0] company_first;
      logic [SUM_WIDTH-1:0] company_second;
   } sums_type;

   typedef struct packed {
      logic                    valid_res;
      logic [TYPE_WIDTH-1:0]   id_type;
      logic [STATUS_WIDTH-1:0] status;
   } verdict_type;

   function automatic logic [DIGIT_WIDTH-1:0] person_first_weight(
      input logic [POS_WIDTH-1:0] p);
      logic [DIGIT_WIDTH-1:0] w;
      w = '0;
      if (p < 4'd9) w = 4'd10 - p;
      return w;
   endfunction

   function automatic logic [DIGIT_WIDTH-1:0] person_second_weight(
      input logic [POS_WIDTH-1:0] p);
      logic [DIGIT_WIDTH-1:0] w;
      w = '0;
      if (p < 4'd10) w = 4'd11 - p;
      return w;
   endfunction

   function automatic logic [DIGIT_WIDTH-1:0] company_first_weight(
      input logic [POS_WIDTH-1:0] p);
      logic [DIGIT_WIDTH-1:0] w;
      w = '0;
      if (p < 4'd4) w = 4'd5 - p;
      else if (p < 4'd12) w = 4'd13 - p;
      return w;
   endfunction

   function automatic logic [DIGIT_WIDTH-1:0] company_second_weight(
      input logic [POS_WIDTH-1:0] p);
      logic [DIGIT_WIDTH-1:0] w;
      w = '0;
      if (p < 4'd5) w = 4'd6 - p;
      else if (p < 4'd13) w = 4'd14 - p;
      return w;
   endfunction

   // Check digit of a weighted sum: remainder mod 11 through a reciprocal
   // multiply and one correcting subtract.
   function automatic logic [DIGIT_WIDTH-1:0] check_of(input logic [SUM_WIDTH-1:0] s);
      logic [17:0] prod;
      logic [6:0]  q;
      logic [4:0]  r;
      logic [DIGIT_WIDTH-1:0] c;
      prod = 18'(s) * 18'(RECIP_11);
      q    = prod[17:11];
      r    = 5'(s - 10'(q) * 10'd11);
      if (r >= 5'd11) r = r - 5'd11;
      c = (r < 5'd2) ? 4'd0 : 4'(5'd11 - r);
      return c;
   endfunction

endpackage

[rtl/core/ccdv_verdict.sv]
module ccdv_verdict (
   input  logic [ccdv_pkg::POS_WIDTH-1:0]   position,
   input  ccdv_pkg::sums_type               sums,
   input  logic                             bad_character,
   input  logic [ccdv_pkg::DIGIT_WIDTH-1:0] previous_digit,
   input  logic [ccdv_pkg::DIGIT_WIDTH-1:0] current_digit,
   output ccdv_pkg::verdict_type            verdict
);

   logic [ccdv_pkg::SUM_WIDTH-1:0]   sum_first;
   logic [ccdv_pkg::SUM_WIDTH-1:0]   sum_second;
   logic [ccdv_pkg::TYPE_WIDTH-1:0]  id_type;
   logic [ccdv_pkg::DIGIT_WIDTH-1:0] check_first;
   logic [ccdv_pkg::DIGIT_WIDTH-1:0] check_second;

   always_comb begin
      id_type    = ccdv_pkg::TYPE_UNKNOWN;
      sum_first  = '0;
      sum_second = '0;
      if (position == ccdv_pkg::POS_LAST_CPF) begin
         id_type    = ccdv_pkg::TYPE_CPF;
         sum_first  = sums.person_first;
         sum_second = sums.person_second;
      end else if (position == ccdv_pkg::POS_LAST_CNPJ) begin
         id_type    = ccdv_pkg::TYPE_CNPJ;
         sum_first  = sums.company_first;
         sum_second = sums.company_second;
      end
   end

   assign check_first  = ccdv_pkg::check_of(sum_first);
   assign check_second = ccdv_pkg::check_of(sum_second);

   always_comb begin
      verdict.id_type   = id_type;
      verdict.valid_res = 1'b0;
      if (id_type == ccdv_pkg::TYPE_UNKNOWN) begin
         verdict.status = ccdv_pkg::ST_BAD_LENGTH;
      end else if (bad_character) begin
         verdict.status = ccdv_pkg::ST_NON_DIGIT;
      end else if (check_first != previous_digit) begin
         verdict.status = ccdv_pkg::ST_FIRST_WRONG;
      end else if (check_second != current_digit) begin
         verdict.status = ccdv_pkg::ST_SECOND_WRONG;
      end else begin
         verdict.status    = ccdv_pkg::ST_OK;
         verdict.valid_res = 1'b1;
      end
   end

endmodule

[rtl/core/cpf_cnpj_check_digit_validator.sv]
// Checks a CPF or CNPJ identifier that arrives as ASCII characters, one per
// req beat, with req_is_final on the last one. Each character is taken into
// an input register and folded into four weighted sums in the next cycle;
// a new character can be taken in every cycle. When the final character
// retires from the input register rsp_valid rises, carrying valid_res, id_type
// (1 CPF for 11 characters, 2 CNPJ for 14, 0 otherwise) and status (0 ok,
// 1 bad length, 2 non-digit, 3 first check digit wrong, 4 second wrong), and
// the sums clear for the next identifier. The input stalls only while a
// final character sits in the input register behind a result that has not
// been taken yet.
module cpf_cnpj_check_digit_validator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ccdv_pkg::CHAR_WIDTH-1:0]   req_char_code,
   input  logic                              req_is_final,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_valid_res,
   output logic [ccdv_pkg::TYPE_WIDTH-1:0]   rsp_id_type,
   output logic [ccdv_pkg::STATUS_WIDTH-1:0] rsp_status
);

   logic                              in_valid_ff, in_valid_in;
   logic [ccdv_pkg::CHAR_WIDTH-1:0]   in_char_ff;
   logic                              in_final_ff;
   logic [ccdv_pkg::POS_WIDTH-1:0]    position_ff, position_in;
   ccdv_pkg::sums_type                sums_ff, sums_in;
   logic [ccdv_pkg::DIGIT_WIDTH-1:0]  previous_digit_ff, previous_digit_in;
   logic                              bad_character_ff, bad_character_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ccdv_pkg::verdict_type             rsp_data_ff;
   ccdv_pkg::verdict_type             verdict;

   logic                              is_digit;
   logic [ccdv_pkg::DIGIT_WIDTH-1:0]  digit;
   logic                              advance;
   logic                              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_final_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign is_digit = (in_char_ff >= ccdv_pkg::CHAR_ZERO) && (in_char_ff <= ccdv_pkg::CHAR_NINE);
   assign digit    = is_digit ? 4'(in_char_ff - ccdv_pkg::CHAR_ZERO) : '0;

   always_comb begin
      sums_in.person_first   = sums_ff.person_first
         + 10'(digit) * 10'(ccdv_pkg::person_first_weight(position_ff));
      sums_in.person_second  = sums_ff.person_second
         + 10'(digit) * 10'(ccdv_pkg::person_second_weight(position_ff));
      sums_in.company_first  = sums_ff.company_first
         + 10'(digit) * 10'(ccdv_pkg::company_first_weight(position_ff));
      sums_in.company_second = sums_ff.company_second
         + 10'(digit) * 10'(ccdv_pkg::company_second_weight(position_ff));
      bad_character_in  = bad_character_ff || !is_digit;
      previous_digit_in = digit;
      position_in       = (position_ff == ccdv_pkg::POS_MAX) ? position_ff
                                                             : position_ff + 4'd1;
   end

   ccdv_verdict u_verdict (
      .position       (position_ff),
      .sums           (sums_in),
      .bad_character  (bad_character_in),
      .previous_digit (previous_digit_ff),
      .current_digit  (digit),
      .verdict        (verdict)
   );

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = (advance && in_final_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         position_ff       <= '0;
         sums_ff           <= '0;
         previous_digit_ff <= '0;
         bad_character_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (in_final_ff) begin
               position_ff       <= '0;
               sums_ff           <= '0;
               previous_digit_ff <= '0;
               bad_character_ff  <= 1'b0;
            end else begin
               position_ff       <= position_in;
               sums_ff           <= sums_in;
               previous_digit_ff <= previous_digit_in;
               bad_character_ff  <= bad_character_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_char_ff  <= req_char_code;
         in_final_ff <= req_is_final;
      end
      if (advance && in_final_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_data_ff.valid_res;
   assign rsp_id_type   = rsp_data_ff.id_type;
   assign rsp_status    = rsp_data_ff.status;

   // A pass is reported exactly when the status says ok.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.valid_res == (rsp_data_ff.status == ccdv_pkg::ST_OK)))
      else $error("valid_res disagrees with status");

   // Unknown type goes with a bad length and nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.id_type == ccdv_pkg::TYPE_UNKNOWN)
                        == (rsp_data_ff.status == ccdv_pkg::ST_BAD_LENGTH)))
      else $error("id_type and bad length status disagree");

   // Retiring a final character raises the result and clears the count.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_final_ff) |=> (rsp_valid_ff && position_ff == '0
                                    && !bad_character_ff))
      else $error("final character did not close the identifier");

   // A result waiting to be taken never lets the final character retire.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && in_valid_ff && in_final_ff) |-> !advance)
      else $error("result overwritten while stalled");

endmodule

[test/cpf_cnpj_check_digit_validator_test.sv]
module cpf_cnpj_check_digit_validator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ccdv_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int CHAR_TARGET = 1200;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CHAR_WIDTH-1:0]   req_char_code;
   logic                    req_is_final;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_valid_res;
   logic [TYPE_WIDTH-1:0]   rsp_id_type;
   logic [STATUS_WIDTH-1:0] rsp_status;

   cpf_cnpj_check_digit_validator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_id_type   (rsp_id_type),
      .rsp_status    (rsp_status)
   );

   // Weight of position p in one of the four sums; zero where the position
   // does not take part.
   function automatic int digit_weight(input bit company, input bit second, input int p);
      if (!company) begin
         if (second) return (p < 10) ? 11 - p : 0;
         return (p < 9) ? 10 - p : 0;
      end
      if (!second) return (p < 4) ? 5 - p : ((p < 12) ? 13 - p : 0);
      return (p < 5) ? 6 - p : ((p < 13) ? 14 - p : 0);
   endfunction

   function automatic int check_digit(input int s);
      int r;
      r = s % 11;
      return (r < 2) ? 0 : 11 - r;
   endfunction

   class id_scoreboard;
      logic [POS_WIDTH-1:0]   position;
      logic [SUM_WIDTH-1:0]   person_first;
      logic [SUM_WIDTH-1:0]   person_second;
      logic [SUM_WIDTH-1:0]   company_first;
      logic [SUM_WIDTH-1:0]   company_second;
      logic [DIGIT_WIDTH-1:0] prev_digit;
      bit                     bad_char;
      verdict_type            verdict_q[$];
      int                     errors;
      int                     chars_seen;
      int                     verdicts_checked;
      int                     status_count[5];

      function new();
         errors = 0;
         chars_seen = 0;
         verdicts_checked = 0;
         foreach (status_count[i]) status_count[i] = 0;
         clear();
      endfunction

      function void clear();
         position = '0;
         person_first = '0;
         person_second = '0;
         company_first = '0;
         company_second = '0;
         prev_digit = '0;
         bad_char = 0;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void note_char(input logic [CHAR_WIDTH-1:0] c, input logic fin);
         logic [POS_WIDTH-1:0]   p;
         logic [DIGIT_WIDTH-1:0] d;
         logic [DIGIT_WIDTH-1:0] prev;
         logic [TYPE_WIDTH-1:0]  kind;
         logic [SUM_WIDTH-1:0]   s1;
         logic [SUM_WIDTH-1:0]   s2;
         bit                     is_digit;
         verdict_type            v;
         chars_seen++;
         p = position;
         prev = prev_digit;
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         d = is_digit ? DIGIT_WIDTH'(c - CHAR_ZERO) : '0;
         if (!is_digit) bad_char = 1;
         person_first   += SUM_WIDTH'(d * digit_weight(0, 0, p));
         person_second  += SUM_WIDTH'(d * digit_weight(0, 1, p));
         company_first  += SUM_WIDTH'(d * digit_weight(1, 0, p));
         company_second += SUM_WIDTH'(d * digit_weight(1, 1, p));
         prev_digit = d;
         if (p != POS_MAX) position = p + 1'b1;
         if (!fin) return;

         kind = TYPE_UNKNOWN;
         s1 = '0;
         s2 = '0;
         if (p == POS_LAST_CPF) begin
            kind = TYPE_CPF;
            s1 = person_first;
            s2 = person_second;
         end else if (p == POS_LAST_CNPJ) begin
            kind = TYPE_CNPJ;
            s1 = company_first;
            s2 = company_second;
         end
         v.valid_res = 1'b0;
         v.id_type = kind;
         if (kind == TYPE_UNKNOWN) begin
            v.status = ST_BAD_LENGTH;
         end else if (bad_char) begin
            v.status = ST_NON_DIGIT;
         end else if (check_digit(s1) != int'(prev)) begin
            v.status = ST_FIRST_WRONG;
         end else if (check_digit(s2) != int'(d)) begin
            v.status = ST_SECOND_WRONG;
         end else begin
            v.status = ST_OK;
            v.valid_res = 1'b1;
         end
         status_count[v.status]++;
         verdict_q.push_back(v);
         clear();
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 30) $display("MISMATCH: %s", msg);
      endtask

      task check_result(input logic vres, input logic [TYPE_WIDTH-1:0] kind,
                        input logic [STATUS_WIDTH-1:0] st);
         verdict_type want;
         if (verdict_q.size() == 0) begin
            report($sformatf("unexpected rsp beat: valid_res %0d id_type %0d status %0d",
                             vres, kind, st));
            return;
         end
         want = verdict_q.pop_front();
         verdicts_checked++;
         if (vres !== want.valid_res)
            report($sformatf("verdict %0d: valid_res %0d, want %0d",
                             verdicts_checked, vres, want.valid_res));
         if (kind !== want.id_type)
            report($sformatf("verdict %0d: id_type %0d, want %0d",
                             verdicts_checked, kind, want.id_type));
         if (st !== want.status)
            report($sformatf("verdict %0d: status %0d, want %0d",
                             verdicts_checked, st, want.status));
      endtask
   endclass

   id_scoreboard          sb;
   logic [CHAR_WIDTH-1:0] id_buf[$];
   int                    sender_gap_max;
   int                    rsp_gap_max;
   bit                    hold_rsp;
   int                    stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Characters of one identifier with correct check digits; fill < 0 draws
   // random body digits.
   task automatic build_valid(input bit company, input int fill);
      int n;
      int s1;
      int s2;
      int c1;
      int dig;
      n = company ? 12 : 9;
      s1 = 0;
      s2 = 0;
      id_buf.delete();
      for (int i = 0; i < n; i++) begin
         dig = (fill < 0) ? $urandom_range(0, 9) : fill;
         id_buf.push_back(CHAR_WIDTH'(CHAR_ZERO + dig));
         s1 += dig * digit_weight(company, 0, i);
         s2 += dig * digit_weight(company, 1, i);
      end
      c1 = check_digit(s1);
      s2 += c1 * digit_weight(company, 1, n);
      id_buf.push_back(CHAR_WIDTH'(CHAR_ZERO + c1));
      id_buf.push_back(CHAR_WIDTH'(CHAR_ZERO + check_digit(s2)));
   endtask

   function automatic logic [CHAR_WIDTH-1:0] non_digit();
      logic [CHAR_WIDTH-1:0] b;
      do b = CHAR_WIDTH'($urandom_range(0, 255));
      while (b >= CHAR_ZERO && b <= CHAR_NINE);
      return b;
   endfunction

   task automatic make_identifier();
      int kind;
      int mut;
      int last;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // Well-formed identifier, sometimes with one planted error.
         build_valid($urandom_range(0, 1), -1);
         last = id_buf.size() - 1;
         mut = $urandom_range(0, 99);
         if (mut < 15) begin
            id_buf[last-1] = CHAR_WIDTH'(CHAR_ZERO
               + (int'(id_buf[last-1] - CHAR_ZERO) + $urandom_range(1, 9)) % 10);
         end else if (mut < 30) begin
            id_buf[last] = CHAR_WIDTH'(CHAR_ZERO
               + (int'(id_buf[last] - CHAR_ZERO) + $urandom_range(1, 9)) % 10);
         end else if (mut < 40) begin
            id_buf[$urandom_range(0, last)] = non_digit();
         end
      end else if (kind < 85) begin
         // Digits only, any length, past the saturation point too.
         id_buf.delete();
         len = $urandom_range(1, 20);
         repeat (len) id_buf.push_back(CHAR_WIDTH'(CHAR_ZERO + $urandom_range(0, 9)));
      end else begin
         id_buf.delete();
         if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? 11 : 14;
         else len = $urandom_range(1, 18);
         repeat (len) id_buf.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      end
   endtask

   // Called just after a falling edge; returns just after a falling edge.
   task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic fin);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_is_final <= fin;
      do @(posedge clock); while (!req_ready);
      sb.note_char(c, fin);
      @(negedge clock);
   endtask

   task automatic send_id(inout int sent);
      int n;
      n = id_buf.size();
      for (int i = 0; i < n; i++) send_char(id_buf[i], i == n - 1);
      sent += n;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() > 0) @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int gap;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            gap = LONG_HOLD;
            hold_rsp = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_valid_res, rsp_id_type, rsp_status);
         if ($urandom_range(0, 7) == 0) rsp_gap_max = $urandom_range(0, 1) ? 9 : 0;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      int ids;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = '0;
      req_is_final = 1'b0;
      rsp_ready = 1'b0;
      hold_rsp = 0;
      sender_gap_max = 9;
      rsp_gap_max = 9;
      stall_cycles = 0;
      sent = 0;
      ids = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: all-zero CPF, all-nine CNPJ body, and single extreme bytes.
      build_valid(0, 0);
      send_id(sent);
      build_valid(1, 9);
      send_id(sent);
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      sent += 2;
      wait_drained();

      while (sent < CHAR_TARGET) begin
         make_identifier();
         if (ids == 20) begin
            // Results back up behind the held receiver until finals stall.
            hold_rsp = 1;
            sender_gap_max = 0;
         end else if (ids == 45) begin
            wait_drained();
         end else if (ids > 24 && $urandom_range(0, 3) == 0) begin
            sender_gap_max = $urandom_range(0, 1) ? 9 : 0;
         end
         send_id(sent);
         ids++;
      end
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d characters and %0d identifiers: %0d ok, %0d bad length,",
               sb.chars_seen, sb.verdicts_checked, sb.status_count[ST_OK],
               sb.status_count[ST_BAD_LENGTH]);
      $display("  %0d non-digit, %0d first digit wrong, %0d second digit wrong.",
               sb.status_count[ST_NON_DIGIT], sb.status_count[ST_FIRST_WRONG],
               sb.status_count[ST_SECOND_WRONG]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ccdv_pkg.sv
rtl/core/ccdv_verdict.sv
rtl/core/cpf_cnpj_check_digit_validator.sv
test/cpf_cnpj_check_digit_validator_test.sv
